// File: design/kab_pkg.sv
// ----------------------------------------------------------------------------
// kab_pkg
// Shared types, constants and helpers for the tilt angle / gyro bias filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kab_pkg;

	localparam int DataW  = 32;
	localparam int AccW   = 40;
	localparam int ProdW  = 38;
	localparam int OpW    = 33;
	localparam int QFrac  = 28;
	localparam int RegIdxW = 4;

	localparam logic [RegIdxW-1:0] REG_ANGLE_NOISE = 4'd0;
	localparam logic [RegIdxW-1:0] REG_BIAS_NOISE  = 4'd1;
	localparam logic [RegIdxW-1:0] REG_MEAS_NOISE  = 4'd2;
	localparam logic [RegIdxW-1:0] REG_PERIOD      = 4'd3;

	localparam logic [DataW-1:0] RST_ANGLE_NOISE = 32'd268435;
	localparam logic [DataW-1:0] RST_BIAS_NOISE  = 32'd805306;
	localparam logic [DataW-1:0] RST_MEAS_NOISE  = 32'd134217728;
	localparam logic [DataW-1:0] RST_PERIOD      = 32'd1342177;
	localparam logic signed [DataW-1:0] ONE_Q28  = 32'sd268435456;

	localparam logic signed [DataW-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DataW-1:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [DataW-1:0] measured_angle;
		logic signed [DataW-1:0] gyro_rate;
	} in_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] angle_out;
		logic signed [DataW-1:0] bias_out;
	} out_item_t;

	typedef struct packed {
		logic [DataW-1:0] angle_noise;
		logic [DataW-1:0] bias_noise;
		logic [DataW-1:0] meas_noise;
		logic [DataW-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic signed [DataW-1:0] num;
		logic [DataW:0]          den;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [DataW-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] x);
		logic signed [DataW-1:0] r;
		if (x > AccW'(S32_MAX))
			r = S32_MAX;
		else if (x < AccW'(S32_MIN))
			r = S32_MIN;
		else
			r = x[DataW-1:0];
		return r;
	endfunction

	function automatic logic signed [AccW-1:0] sx32(input logic signed [DataW-1:0] x);
		return {{(AccW-DataW){x[DataW-1]}}, x};
	endfunction

	function automatic logic signed [AccW-1:0] sxp(input logic signed [ProdW-1:0] x);
		return {{(AccW-ProdW){x[ProdW-1]}}, x};
	endfunction

endpackage

`default_nettype wire

// File: design/kalman_angle_bias_filter_unit.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_unit
// Two-state tilt Kalman filter: angle and gyro bias from accelerometer angle
// and gyro rate, Q16.16 states, Q4.28 covariance, one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: predict steps, two serial divisions of 31 quotient bits for the
//   gains, correct steps, then the registered output.
// A new item is taken only while the core is idle, after the last result is
//   taken; a saturated gain or non-positive variance cuts the divisions short.
// Reset: arst_n clears the state to angle 0, bias 0, identity covariance,
//   and loads the default tuning registers.
`default_nettype none

module kalman_angle_bias_filter_unit import kab_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_data,
	input  wire logic               wr_en,
	input  wire logic [RegIdxW-1:0] wr_index,
	input  wire logic [DataW-1:0]   wr_data
);

	cfg_t      cfg_q;
	logic      idle;
	logic      res_valid;
	logic      res_take;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_noise <= RST_ANGLE_NOISE;
			cfg_q.bias_noise  <= RST_BIAS_NOISE;
			cfg_q.meas_noise  <= RST_MEAS_NOISE;
			cfg_q.period      <= RST_PERIOD;
		end else if (wr_en) begin
			case (wr_index)
				REG_ANGLE_NOISE: cfg_q.angle_noise <= wr_data;
				REG_BIAS_NOISE:  cfg_q.bias_noise  <= wr_data;
				REG_MEAS_NOISE:  cfg_q.meas_noise  <= wr_data;
				REG_PERIOD:      cfg_q.period      <= wr_data;
				default: ;
			endcase
		end
	end

	assign in_ready = idle;
	assign res_take = res_valid && (!out_valid_q || out_ready);

	kab_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_valid && in_ready),
		.item      (in_data),
		.idle      (idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_take)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: design/kab_mul.sv
// ----------------------------------------------------------------------------
// kab_mul
// Shared 33x33 signed multiplier, product floored by 2^28 and registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kab_mul import kab_pkg::*; (
	input  wire logic                    clk,
	input  wire logic signed [OpW-1:0]   op_a,
	input  wire logic signed [OpW-1:0]   op_b,
	output logic signed [ProdW-1:0]      prod_q
);

	logic signed [2*OpW-1:0] full;

	assign full = op_a * op_b;

	// taking the upper bits is a floor shift
	always_ff @(posedge clk) begin
		prod_q <= full[QFrac+ProdW-1:QFrac];
	end

endmodule

`default_nettype wire

// File: design/kab_div.sv
// ----------------------------------------------------------------------------
// kab_div
// Radix-2 restoring divider: (num * 2^28) / den, truncated toward zero,
// saturated to 32 bits. den is positive. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kab_div import kab_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int QW = DataW - 1;

	logic            busy_q;
	logic            done_q;
	logic [4:0]      cnt_q;
	logic            neg_q;
	logic [DataW:0]  den_q;
	logic [DataW:0]  rem_q;
	logic [QW-1:0]   low_q;
	logic [QW-1:0]   q_q;
	logic signed [DataW-1:0] quo_q;

	logic [DataW-1:0] mag;
	logic             ovf;
	logic [DataW+1:0] trial;
	logic [DataW+1:0] diff;
	logic             ge;
	logic [QW-1:0]    q_next;

	assign mag   = req.num[DataW-1] ? (~req.num + 1'b1) : req.num;
	assign ovf   = {4'd0, mag[DataW-1:3]} >= req.den;
	assign trial = {rem_q, low_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign q_next = {q_q[QW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(QW - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[DataW-1];
			den_q <= req.den;
			rem_q <= {4'd0, mag[DataW-1:3]};
			low_q <= {mag[2:0], {QFrac{1'b0}}};
			q_q   <= '0;
			if (ovf)
				quo_q <= req.num[DataW-1] ? S32_MIN : S32_MAX;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DataW:0] : trial[DataW:0];
			low_q <= {low_q[QW-2:0], 1'b0};
			q_q   <= q_next;
			if (cnt_q == '0)
				quo_q <= neg_q ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

// File: design/kab_core.sv
// ----------------------------------------------------------------------------
// kab_core
// Filter state and sequencer: predict, covariance propagation, gains and
// correction, all products through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module kab_core import kab_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     start,
	input  wire in_item_t item,
	output logic          idle,
	output logic          res_valid,
	input  wire logic     res_take,
	output out_item_t     res
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRED = 6'b000010,
		ST_DIV0 = 6'b000100,
		ST_DIV1 = 6'b001000,
		ST_CORR = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	localparam logic [2:0] LAST_STEP = 3'd6;

	state_t state_q;
	logic [2:0] step_q;

	logic signed [DataW-1:0] meas_q, rate_q;
	logic signed [DataW-1:0] ang_q, bias_q;
	logic signed [DataW-1:0] c00_q, c01_q, c10_q, c11_q;
	logic signed [DataW-1:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [DataW-1:0] err_q, k0_q, k1_q;
	logic signed [AccW-1:0]  acc_q;

	logic signed [DataW-1:0] rc;
	logic signed [OpW-1:0]   op_a, op_b;
	logic signed [ProdW-1:0] prod;
	logic signed [AccW-1:0]  prod_x;
	logic signed [DataW+1:0] e;
	logic                    e_pos;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	function automatic logic signed [OpW-1:0] sop(input logic signed [DataW-1:0] x);
		return {x[DataW-1], x};
	endfunction

	function automatic logic signed [OpW-1:0] uop(input logic [DataW-1:0] x);
		return {1'b0, x};
	endfunction

	assign rc     = sat32(sx32(rate_q) - sx32(bias_q));
	assign prod_x = sxp(prod);
	assign e      = $signed({2'b00, cfg.meas_noise}) + {{2{p00_q[DataW-1]}}, p00_q};
	assign e_pos  = !e[DataW+1] && (e != '0);

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_PRED) begin
			op_b = uop(cfg.period);
			case (step_q)
				3'd0: op_a = sop(rc);
				3'd1: op_a = uop(cfg.angle_noise);
				3'd2: op_a = sop(c01_q);
				3'd3: op_a = sop(c10_q);
				3'd4: op_a = sop(c11_q);
				3'd5: op_a = uop(cfg.bias_noise);
				default: op_a = '0;
			endcase
		end else if (state_q == ST_CORR) begin
			case (step_q)
				3'd0: begin op_a = sop(k0_q); op_b = sop(p00_q); end
				3'd1: begin op_a = sop(k0_q); op_b = sop(p01_q); end
				3'd2: begin op_a = sop(k1_q); op_b = sop(p00_q); end
				3'd3: begin op_a = sop(k1_q); op_b = sop(p01_q); end
				3'd4: begin op_a = sop(k0_q); op_b = sop(err_q); end
				3'd5: begin op_a = sop(k1_q); op_b = sop(err_q); end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end
	end

	assign div_req.start = ((state_q == ST_PRED) && (step_q == LAST_STEP) && e_pos)
		|| ((state_q == ST_DIV0) && div_rsp.done);
	assign div_req.num   = (state_q == ST_DIV0) ? p10_q : p00_q;
	assign div_req.den   = e[DataW:0];

	kab_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod)
	);

	kab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ang_q   <= '0;
			bias_q  <= '0;
			c00_q   <= ONE_Q28;
			c01_q   <= '0;
			c10_q   <= '0;
			c11_q   <= ONE_Q28;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PRED;
						step_q  <= '0;
					end
				end
				ST_PRED: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd1)
						ang_q <= sat32(sx32(ang_q) + prod_x);
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= e_pos ? ST_DIV0 : ST_CORR;
					end
				end
				ST_DIV0: begin
					if (div_rsp.done)
						state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						state_q <= ST_CORR;
						step_q  <= '0;
					end
				end
				ST_CORR: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						3'd1: c00_q  <= sat32(sx32(p00_q) - prod_x);
						3'd2: c01_q  <= sat32(sx32(p01_q) - prod_x);
						3'd3: c10_q  <= sat32(sx32(p10_q) - prod_x);
						3'd4: c11_q  <= sat32(sx32(p11_q) - prod_x);
						3'd5: ang_q  <= sat32(sx32(ang_q) + prod_x);
						3'd6: bias_q <= sat32(sx32(bias_q) + prod_x);
						default: ;
					endcase
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			meas_q <= item.measured_angle;
			rate_q <= item.gyro_rate;
		end
		if (state_q == ST_PRED) begin
			case (step_q)
				3'd1: acc_q <= sx32(c00_q);
				3'd2: acc_q <= acc_q + prod_x;
				3'd3: acc_q <= acc_q - prod_x;
				3'd4: p00_q <= sat32(acc_q - prod_x);
				3'd5: begin
					p01_q <= sat32(sx32(c01_q) - prod_x);
					p10_q <= sat32(sx32(c10_q) - prod_x);
				end
				3'd6: begin
					p11_q <= sat32(sx32(c11_q) + prod_x);
					err_q <= sat32(sx32(meas_q) - sx32(ang_q));
					if (!e_pos) begin
						k0_q <= '0;
						k1_q <= '0;
					end
				end
				default: ;
			endcase
		end
		if ((state_q == ST_DIV0) && div_rsp.done)
			k0_q <= div_rsp.quo;
		if ((state_q == ST_DIV1) && div_rsp.done)
			k1_q <= div_rsp.quo;
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res.angle_out = ang_q;
	assign res.bias_out  = bias_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV0 || state_q == ST_DIV1))
		else $error("divider finished outside a gain phase");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_corr_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORR && step_q == LAST_STEP) |=> (state_q == ST_OUT))
		else $error("correction did not end in result state");

	a_div_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> e_pos)
		else $error("division started with non-positive variance");

endmodule

`default_nettype wire

// File: verif/kalman_angle_bias_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_unit_tb
// Self-checking bench for the tilt angle / gyro bias Kalman filter. An
// in-bench fixed-point model of the filter predicts the angle and bias
// estimate for every accepted sample. Runs corner samples and about a
// thousand random ones across reset, extreme and random tuning, with random
// gaps and stalls on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_angle_bias_filter_unit_tb import kab_pkg::*; ();

	class tilt_filter_board;
		bit [DataW-1:0] q_angle = RST_ANGLE_NOISE;
		bit [DataW-1:0] q_bias  = RST_BIAS_NOISE;
		bit [DataW-1:0] r_meas  = RST_MEAS_NOISE;
		bit [DataW-1:0] period  = RST_PERIOD;

		int est_angle = 0;
		int est_bias  = 0;
		int cov_aa    = ONE_Q28;
		int cov_ab    = 0;
		int cov_ba    = 0;
		int cov_bb    = ONE_Q28;

		out_item_t expected_estimates[$];
		int samples_in  = 0;
		int estimates_checked = 0;
		int mismatches  = 0;

		function int clip32(longint x);
			if (x > longint'(S32_MAX))
				return S32_MAX;
			if (x < longint'(S32_MIN))
				return S32_MIN;
			return int'(x);
		endfunction

		function longint scaled_su(int a, bit [DataW-1:0] b);
			return (longint'(a) * longint'({32'b0, b})) >>> QFrac;
		endfunction

		function longint scaled_ss(int a, int b);
			return (longint'(a) * longint'(b)) >>> QFrac;
		endfunction

		function longint scaled_uu(bit [DataW-1:0] a, bit [DataW-1:0] b);
			bit [63:0] pr;
			pr = {32'b0, a} * {32'b0, b};
			return longint'(pr >> QFrac);
		endfunction

		function void set_tuning(logic [RegIdxW-1:0] idx, logic [DataW-1:0] v);
			case (idx)
				REG_ANGLE_NOISE: q_angle = v;
				REG_BIAS_NOISE:  q_bias  = v;
				REG_MEAS_NOISE:  r_meas  = v;
				REG_PERIOD:      period  = v;
				default: ;
			endcase
		endfunction

		function out_item_t predict_estimate(in_item_t s);
			int rc, p00, p01, p10, p11, err, k0, k1;
			longint e;
			out_item_t res;
			rc = clip32(longint'(s.gyro_rate) - longint'(est_bias));
			est_angle = clip32(longint'(est_angle) + scaled_su(rc, period));

			p00 = clip32(longint'(cov_aa) + scaled_uu(q_angle, period)
				- scaled_su(cov_ab, period) - scaled_su(cov_ba, period));
			p01 = clip32(longint'(cov_ab) - scaled_su(cov_bb, period));
			p10 = clip32(longint'(cov_ba) - scaled_su(cov_bb, period));
			p11 = clip32(longint'(cov_bb) + scaled_uu(q_bias, period));

			err = clip32(longint'(s.measured_angle) - longint'(est_angle));
			e = longint'({32'b0, r_meas}) + longint'(p00);
			if (e > 0) begin
				k0 = clip32((longint'(p00) * longint'(ONE_Q28)) / e);
				k1 = clip32((longint'(p10) * longint'(ONE_Q28)) / e);
			end else begin
				k0 = 0;
				k1 = 0;
			end

			cov_aa = clip32(longint'(p00) - scaled_ss(k0, p00));
			cov_ab = clip32(longint'(p01) - scaled_ss(k0, p01));
			cov_ba = clip32(longint'(p10) - scaled_ss(k1, p00));
			cov_bb = clip32(longint'(p11) - scaled_ss(k1, p01));

			est_angle = clip32(longint'(est_angle) + scaled_ss(k0, err));
			est_bias  = clip32(longint'(est_bias) + scaled_ss(k1, err));

			res.angle_out = est_angle;
			res.bias_out  = est_bias;
			return res;
		endfunction

		function void note_sample(in_item_t s);
			expected_estimates.push_back(predict_estimate(s));
			samples_in++;
		endfunction

		function int pending();
			return expected_estimates.size();
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_estimate(out_item_t got);
			out_item_t want;
			if (expected_estimates.size() == 0) begin
				report($sformatf("unexpected item angle=%h bias=%h",
					got.angle_out, got.bias_out));
				return;
			end
			want = expected_estimates.pop_front();
			estimates_checked++;
			if (got.angle_out !== want.angle_out)
				report($sformatf("item %0d angle_out got %h want %h",
					estimates_checked, got.angle_out, want.angle_out));
			if (got.bias_out !== want.bias_out)
				report($sformatf("item %0d bias_out got %h want %h",
					estimates_checked, got.bias_out, want.bias_out));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 wr_en;
	logic [RegIdxW-1:0]   wr_index;
	logic [DataW-1:0]     wr_data;

	tilt_filter_board board = new();
	bit no_gaps = 1'b0;
	int corners [6] = '{0, 1, -1, S32_MAX, S32_MIN, 32'h5555_5555};

	kalman_angle_bias_filter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1_000_000);
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_estimate(out_data);
	end

	// result side: random stall before taking each item
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_sample(input in_item_t s);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
		board.note_sample(s);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_tuning(input logic [DataW-1:0] qa, qg, rn, dt);
		logic [RegIdxW-1:0] junk_idx;
		logic [DataW-1:0]   junk_val;
		junk_idx = RegIdxW'($urandom_range(int'(REG_PERIOD) + 1, (1 << RegIdxW) - 1));
		junk_val = $urandom;
		wr_en    <= 1'b1;
		wr_index <= REG_ANGLE_NOISE;
		wr_data  <= qa;
		board.set_tuning(REG_ANGLE_NOISE, qa);
		@(posedge clk);
		wr_index <= REG_BIAS_NOISE;
		wr_data  <= qg;
		board.set_tuning(REG_BIAS_NOISE, qg);
		@(posedge clk);
		wr_index <= REG_MEAS_NOISE;
		wr_data  <= rn;
		board.set_tuning(REG_MEAS_NOISE, rn);
		@(posedge clk);
		wr_index <= REG_PERIOD;
		wr_data  <= dt;
		board.set_tuning(REG_PERIOD, dt);
		@(posedge clk);
		// unmapped index, must be ignored
		wr_index <= junk_idx;
		wr_data  <= junk_val;
		board.set_tuning(junk_idx, junk_val);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [DataW-1:0] draw_tuning();
		case ($urandom_range(0, 2))
			0:       return $urandom;
			1:       return $urandom_range(0, 1 << 24);
			default: return $urandom_range(0, 1 << 28);
		endcase
	endfunction

	function automatic in_item_t draw_sample();
		int pick;
		in_item_t s;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			// plausible tilt and rate
			s.measured_angle = int'($urandom_range(0, 180 << 16)) - (90 << 16);
			s.gyro_rate      = int'($urandom_range(0, 500 << 16)) - (250 << 16);
		end else if (pick < 85) begin
			s.measured_angle = $urandom;
			s.gyro_rate      = $urandom;
		end else begin
			s.measured_angle = corners[$urandom_range(0, 5)];
			s.gyro_rate      = corners[$urandom_range(0, 5)];
		end
		return s;
	endfunction

	initial begin
		logic [DataW-1:0] qa, qg, rn, dt;
		in_item_t s;
		int n_phases;
		n_phases = 9;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		wr_en    <= 1'b0;
		wr_index <= '0;
		wr_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < n_phases; p++) begin
			no_gaps = (p % 3 == 2);
			case (p)
				0: begin qa = RST_ANGLE_NOISE; qg = RST_BIAS_NOISE;
					rn = RST_MEAS_NOISE; dt = RST_PERIOD; end
				1: begin qa = '0; qg = '0; rn = 32'd1; dt = '0; end
				2: begin qa = '1; qg = '1; rn = '1; dt = '1; end
				3: begin qa = '1; qg = '0; rn = 32'd1; dt = '1; end
				4: begin qa = RST_ANGLE_NOISE; qg = RST_BIAS_NOISE;
					rn = RST_MEAS_NOISE; dt = RST_PERIOD; end
				default: begin
					qa = draw_tuning();
					qg = draw_tuning();
					rn = draw_tuning();
					dt = draw_tuning();
					if (rn == '0)
						rn = 32'd1;
				end
			endcase
			if (p != 0)
				load_tuning(qa, qg, rn, dt);

			if (p == 0) begin
				for (int i = 0; i < 6; i++) begin
					s.measured_angle = corners[i];
					s.gyro_rate      = corners[(i * 2 + 1) % 6];
					send_sample(s);
					s.measured_angle = corners[(i + 3) % 6];
					s.gyro_rate      = corners[i];
					send_sample(s);
				end
			end else if (p <= 3) begin
				for (int i = 0; i < 4; i++) begin
					s.measured_angle = corners[i];
					s.gyro_rate      = corners[5 - i];
					send_sample(s);
				end
			end

			for (int i = 0; i < 110; i++) begin
				send_sample(draw_sample());
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d estimates never arrived", board.pending()));
		$display("Sent %0d samples over %0d tuning sets: reset, extremes, random.",
			board.samples_in, n_phases);
		$display("Compared %0d estimates, %0d mismatches.",
			board.estimates_checked, board.mismatches);
		if (board.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
